/* rtl/four_way_transposition_table_core_macros.svh */
// ----------------------------------------------------------------------------
// Transposition table assertion macros
// Concurrent assertion wrappers used by the transposition table datapath.
// Defining ASSERT_OFF compiles every check away.
// ----------------------------------------------------------------------------
`ifndef FOUR_WAY_TRANSPOSITION_TABLE_CORE_MACROS_SVH
`define FOUR_WAY_TRANSPOSITION_TABLE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define FTT_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define FTT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FTT_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg)
`define FTT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

/* rtl/ftt_pkg.sv */
// ----------------------------------------------------------------------------
// Transposition table package
// Entry layout, operation codes and controller interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftt_pkg;

  localparam int WAYS = 4;
  localparam int WAY_W = $clog2(WAYS);

  localparam logic OP_STORE    = 1'b0;
  localparam logic OP_RETRIEVE = 1'b1;

  localparam int KIND_LOWER_BIT = 0;
  localparam int KIND_UPPER_BIT = 1;

  typedef struct packed {
    logic [63:0]        key;
    logic [16:0]        move;
    logic [1:0]         kind;
    logic               threat;
    logic [7:0]         gen;
    logic signed [15:0] score;
    logic signed [15:0] depth;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } ftt_state_t;

  typedef struct packed {
    logic clear_en;
    logic capture;
    logic commit;
  } ftt_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } ftt_sts_t;

endpackage

/* rtl/ftt_ctrl.sv */
// ----------------------------------------------------------------------------
// Transposition table controller
// Sequences the clearing pass, bucket read and bucket evaluate/write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftt_ctrl
  import ftt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ftt_sts_t sts,
  output ftt_cmd_t cmd
);

  ftt_state_t state_r;
  ftt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/ftt_datapath.sv */
// ----------------------------------------------------------------------------
// Transposition table datapath
// Bucket memory, request registers, way compare and victim choice, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "four_way_transposition_table_core_macros.svh"

module ftt_datapath
  import ftt_pkg::*;
#(
  parameter int BUCKET_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ftt_cmd_t           cmd,
  output ftt_sts_t           sts,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_operation,
  input  logic [63:0]        in_position_key,
  input  logic signed [15:0] in_store_score,
  input  logic signed [15:0] in_store_depth,
  input  logic [16:0]        in_store_move,
  input  logic [1:0]         in_bound_kind,
  input  logic               in_threat_flag,
  input  logic signed [15:0] in_alpha_in,
  input  logic signed [15:0] in_beta_in,
  input  logic signed [15:0] in_probe_depth,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic signed [15:0] out_alpha_out,
  output logic signed [15:0] out_beta_out,
  output logic [16:0]        out_found_move,
  output logic               out_found_threat,
  output logic               out_forbid_null
);

  localparam int IDX_W = $clog2(BUCKET_COUNT);
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(BUCKET_COUNT - 1);

  row_t mem [BUCKET_COUNT];

  logic [7:0]         gen_r;
  logic [IDX_W-1:0]   clr_cnt_r;
  row_t               rd_row_r;
  logic [IDX_W-1:0]   idx_r;
  logic               op_r;
  logic [63:0]        key_r;
  logic signed [15:0] score_r;
  logic signed [15:0] depth_r;
  logic [16:0]        move_r;
  logic [1:0]         kind_r;
  logic               threat_r;
  logic signed [15:0] alpha_r;
  logic signed [15:0] beta_r;
  logic signed [15:0] need_r;

  logic               out_valid_r;
  logic               hit_r;
  logic signed [15:0] alpha_out_r;
  logic signed [15:0] beta_out_r;
  logic [16:0]        found_move_r;
  logic               found_threat_r;
  logic               forbid_null_r;

  logic [IDX_W-1:0]   in_idx;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_addr;
  row_t               wr_row;

  logic               any_match;
  logic [WAY_W-1:0]   match_way;
  logic [WAY_W-1:0]   victim_way;
  entry_t             hit_entry;
  entry_t             new_entry;
  logic               res_hit;
  logic signed [15:0] res_alpha;
  logic signed [15:0] res_beta;
  logic [16:0]        res_move;
  logic               res_threat;
  logic               res_forbid;

  assign in_idx = in_position_key[IDX_W-1:0] & IDX_MASK;

  // Configuration register and clearing pass counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) gen_r <= cfg_wdata;
      if (cmd.clear_en) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clear_last = (clr_cnt_r == IDX_MASK);
  assign sts.out_free   = !out_valid_r || out_ready;

  // Request capture together with the registered bucket read.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r    <= in_idx;
      op_r     <= in_operation;
      key_r    <= in_position_key;
      score_r  <= in_store_score;
      depth_r  <= in_store_depth;
      move_r   <= in_store_move;
      kind_r   <= in_bound_kind;
      threat_r <= in_threat_flag;
      alpha_r  <= in_alpha_in;
      beta_r   <= in_beta_in;
      need_r   <= in_probe_depth;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) rd_row_r <= mem[in_idx];
    if (mem_we) mem[wr_addr] <= wr_row;
  end

  // First matching way and replacement victim.
  always_comb begin
    logic cand_cur;
    logic way_cur;
    any_match  = 1'b0;
    match_way  = '0;
    victim_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (rd_row_r[i].key == key_r) begin
        any_match = 1'b1;
        match_way = WAY_W'(i);
      end
    end
    for (int i = 1; i < WAYS; i++) begin
      cand_cur = (rd_row_r[victim_way].gen == gen_r);
      way_cur  = (rd_row_r[i].gen == gen_r);
      if (cand_cur) begin
        if (!way_cur || (rd_row_r[i].depth < rd_row_r[victim_way].depth)) begin
          victim_way = WAY_W'(i);
        end
      end else if (!way_cur && (rd_row_r[i].depth < rd_row_r[victim_way].depth)) begin
        victim_way = WAY_W'(i);
      end
    end
  end

  assign hit_entry = rd_row_r[match_way];

  always_comb begin
    new_entry.key    = key_r;
    new_entry.move   = (any_match && (move_r == '0)) ? hit_entry.move : move_r;
    new_entry.kind   = kind_r;
    new_entry.threat = threat_r;
    new_entry.gen    = gen_r;
    new_entry.score  = score_r;
    new_entry.depth  = depth_r;
  end

  always_comb begin
    wr_row  = rd_row_r;
    wr_addr = idx_r;
    if (cmd.clear_en) begin
      wr_row  = '0;
      wr_addr = clr_cnt_r;
    end else if (any_match) begin
      wr_row[match_way] = new_entry;
    end else begin
      wr_row[victim_way] = new_entry;
    end
  end

  assign mem_we = cmd.clear_en || (cmd.commit && (op_r == OP_STORE));

  // Retrieve result; a store reports all zero fields.
  always_comb begin
    logic deep;
    logic is_lower;
    logic is_upper;
    deep       = (hit_entry.depth >= need_r);
    is_lower   = hit_entry.kind[KIND_LOWER_BIT];
    is_upper   = hit_entry.kind[KIND_UPPER_BIT];
    res_hit    = 1'b0;
    res_alpha  = '0;
    res_beta   = '0;
    res_move   = '0;
    res_threat = 1'b0;
    res_forbid = 1'b0;
    if (op_r == OP_RETRIEVE) begin
      res_alpha = alpha_r;
      res_beta  = beta_r;
      if (any_match) begin
        res_hit    = 1'b1;
        res_move   = hit_entry.move;
        res_threat = hit_entry.threat;
        res_forbid = is_upper && (hit_entry.score < beta_r);
        if (deep && is_lower && (hit_entry.score > alpha_r)) res_alpha = hit_entry.score;
        if (deep && is_upper && (hit_entry.score < beta_r))  res_beta  = hit_entry.score;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r          <= res_hit;
      alpha_out_r    <= res_alpha;
      beta_out_r     <= res_beta;
      found_move_r   <= res_move;
      found_threat_r <= res_threat;
      forbid_null_r  <= res_forbid;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_r;
  assign out_alpha_out    = alpha_out_r;
  assign out_beta_out     = beta_out_r;
  assign out_found_move   = found_move_r;
  assign out_found_threat = found_threat_r;
  assign out_forbid_null  = forbid_null_r;

  `FTT_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.commit, !out_valid_r || out_ready, "pending result overwritten")
  `FTT_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, out_valid_r, "committed result not presented")
  `FTT_ASSERT_IMPL(a_clear_alone, clk, rst_n, cmd.clear_en, !cmd.commit && !cmd.capture, "request during clearing pass")
  `FTT_ASSERT_IMPL(a_clear_no_out, clk, rst_n, cmd.clear_en, !out_valid_r, "result pending during clearing pass")

endmodule

/* rtl/four_way_transposition_table_core.sv */
// ----------------------------------------------------------------------------
// Four-way transposition table core
// Hashed table of four-way buckets with store and retrieve transactions.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes the bucket memory one row per cycle, with
// in_ready held low; configuration writes are taken during that pass. For each
// transaction the accepting edge reads the whole bucket row from the single-port
// memory; in the evaluate state the core then compares all four ways and, once
// the result register is free, writes the updated row back for a store and
// loads the result register. One transaction is in flight at a time, so the
// next is accepted only after the previous one is committed; a result that is
// not taken holds the core in its evaluate state until out_ready frees the
// result register. Every transaction, store or retrieve, yields exactly one
// result. The search generation should be written only while the core is idle.
`timescale 1ns / 1ps

module four_way_transposition_table_core
  import ftt_pkg::*;
#(
  parameter int BUCKET_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration: the search generation register.
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  // Request channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [63:0]        in_position_key,
  input  logic signed [15:0] in_store_score,
  input  logic signed [15:0] in_store_depth,
  input  logic [16:0]        in_store_move,
  input  logic [1:0]         in_bound_kind,
  input  logic               in_threat_flag,
  input  logic signed [15:0] in_alpha_in,
  input  logic signed [15:0] in_beta_in,
  input  logic signed [15:0] in_probe_depth,
  // Result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic signed [15:0] out_alpha_out,
  output logic signed [15:0] out_beta_out,
  output logic [16:0]        out_found_move,
  output logic               out_found_threat,
  output logic               out_forbid_null
);

  // The controller issues commands; the datapath reports clearing progress and
  // whether the result register can take a new result.
  ftt_cmd_t cmd;
  ftt_sts_t sts;

  ftt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the bucket memory, the request registers, the way
  // compare and victim selection, and the result register.
  ftt_datapath #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_operation     (in_operation),
    .in_position_key  (in_position_key),
    .in_store_score   (in_store_score),
    .in_store_depth   (in_store_depth),
    .in_store_move    (in_store_move),
    .in_bound_kind    (in_bound_kind),
    .in_threat_flag   (in_threat_flag),
    .in_alpha_in      (in_alpha_in),
    .in_beta_in       (in_beta_in),
    .in_probe_depth   (in_probe_depth),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_alpha_out    (out_alpha_out),
    .out_beta_out     (out_beta_out),
    .out_found_move   (out_found_move),
    .out_found_threat (out_found_threat),
    .out_forbid_null  (out_forbid_null)
  );

endmodule
